// File: hw/rtl/ubh_pkg.sv
`default_nettype none
package ubh_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_BIN_COUNT = 2'd0;
   localparam logic [1:0] CSR_RANGE_MIN = 2'd1;
   localparam logic [1:0] CSR_BIN_WIDTH = 2'd2;

   // request operation codes
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam int DIFF_WIDTH = 33;
   localparam int DIV_STEPS  = 33;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch request, start divide
      logic div_step;  // one restoring divide step
      logic mem_read;  // issue store read
      logic mem_write; // write updated count, present result
      logic clr_step;  // clear one entry
   } ubh_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_last;
      logic clr_last;
      logic need_div;
   } ubh_stat_type;

endpackage
`default_nettype wire

// File: hw/rtl/ubh_ctrl.sv
`default_nettype none
module ubh_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   output ubh_pkg::ubh_cmd_type      cmd,
   input  wire ubh_pkg::ubh_stat_type stat
);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_READ  = 6'b001000,
      ST_WAIT  = 6'b010000,
      ST_WRITE = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!stat.need_div || stat.div_last) begin
               state_in = ST_READ;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_WAIT;
         end
         ST_WAIT: state_in = ST_WRITE;
         ST_WRITE: begin
            cmd.mem_write = 1'b1;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

// File: hw/rtl/ubh_datapath.sv
`default_nettype none
module ubh_datapath #(
   parameter int MAX_BINS    = 1024,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ubh_pkg::ubh_cmd_type  cmd,
   output ubh_pkg::ubh_stat_type      stat,
   input  wire logic                  csr_valid,
   input  wire logic [1:0]            csr_index,
   input  wire logic [31:0]           csr_data,
   input  wire logic                  req_operation,
   input  wire logic signed [31:0]    req_sample_value,
   input  wire logic                  req_sample_invalid,
   input  wire logic [9:0]            req_bin_select,
   input  wire logic                  req_clear_after_read,
   output logic                       rsp_strobe,
   output logic [9:0]                 rsp_bin_index,
   output logic [31:0]                rsp_bin_total,
   output logic                       rsp_sample_counted
);

   localparam int AW = $clog2(MAX_BINS);
   localparam int DW = ubh_pkg::DIFF_WIDTH;
   localparam int SW = $clog2(ubh_pkg::DIV_STEPS + 1);
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

   // configuration registers
   logic [10:0] bins_ff;
   logic signed [31:0] rmin_ff;
   logic [30:0] width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bins_ff  <= 11'd1024;
         rmin_ff  <= '0;
         width_ff <= 31'd65536;
      end else if (csr_valid) begin
         case (csr_index)
            ubh_pkg::CSR_BIN_COUNT: bins_ff  <= csr_data[10:0];
            ubh_pkg::CSR_RANGE_MIN: rmin_ff  <= csr_data;
            ubh_pkg::CSR_BIN_WIDTH: width_ff <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // request capture and restoring divider
   logic        op_ff, clr_ff, skip_ff, neg_ff;
   logic [9:0]  sel_ff;
   logic [DW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [30:0] div_ff;
   logic [SW-1:0] step_ff;
   logic signed [DW-1:0] diff;
   logic [DW:0] trial;

   assign diff  = DW'(req_sample_value) - DW'(rmin_ff);
   assign trial = {rem_ff, quo_ff[DW-1]} - {3'b0, div_ff};

   always_comb begin
      rem_in = {rem_ff[DW-2:0], quo_ff[DW-1]};
      quo_in = {quo_ff[DW-2:0], 1'b0};
      if (!trial[DW]) begin
         rem_in = trial[DW-1:0];
         quo_in[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         clr_ff  <= req_clear_after_read;
         skip_ff <= req_sample_invalid;
         sel_ff  <= req_bin_select;
         neg_ff  <= diff[DW-1];
         quo_ff  <= diff;
         rem_ff  <= '0;
         div_ff  <= (width_ff == '0) ? 31'd1 : width_ff;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff + SW'(1);
      end
   end

   assign stat.div_last = (step_ff == SW'(ubh_pkg::DIV_STEPS));
   assign stat.need_div = (op_ff == ubh_pkg::OP_ADD) && !skip_ff && !neg_ff;

   // bin selection with clamping
   logic [16:0] last;
   logic [AW-1:0] addr;
   logic in_store;
   always_comb begin
      if (bins_ff == '0) last = '0;
      else if (17'(bins_ff) > 17'(MAX_BINS)) last = 17'(MAX_BINS - 1);
      else last = 17'(bins_ff) - 17'd1;
      in_store = 1'b1;
      if (op_ff == ubh_pkg::OP_READ) begin
         addr = AW'(sel_ff);
         in_store = (32'(sel_ff) < 32'(MAX_BINS));
      end else if (neg_ff) begin
         addr = '0;
      end else if (quo_ff > DW'(last)) begin
         addr = AW'(last);
      end else begin
         addr = AW'(quo_ff);
      end
   end

   // count store with reset clearing sweep
   logic [COUNT_WIDTH-1:0] mem [MAX_BINS];
   logic [COUNT_WIDTH-1:0] rd_ff;
   logic [AW-1:0] sweep_ff;
   logic [AW-1:0] addr_ff;
   logic [COUNT_WIDTH-1:0] newc;

   assign stat.clr_last = (sweep_ff == AW'(MAX_BINS - 1));

   always_ff @(posedge clock) begin
      if (reset) sweep_ff <= '0;
      else if (cmd.clr_step) sweep_ff <= sweep_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) addr_ff <= addr;
      if (cmd.mem_read) rd_ff <= mem[addr];
      if (cmd.clr_step) mem[sweep_ff] <= '0;
      else if (cmd.mem_write && in_store) begin
         if (op_ff == ubh_pkg::OP_ADD) begin
            if (!skip_ff) mem[addr_ff] <= newc;
         end else if (clr_ff) begin
            mem[addr_ff] <= '0;
         end
      end
   end

   assign newc = (rd_ff == CMAX) ? rd_ff : rd_ff + COUNT_WIDTH'(1);

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_strobe <= 1'b0;
      else       rsp_strobe <= cmd.mem_write;
      if (cmd.mem_write) begin
         if (op_ff == ubh_pkg::OP_READ) begin
            rsp_bin_index      <= sel_ff;
            rsp_bin_total      <= in_store ? 32'(rd_ff) : '0;
            rsp_sample_counted <= 1'b0;
         end else if (skip_ff) begin
            rsp_bin_index      <= '0;
            rsp_bin_total      <= '0;
            rsp_sample_counted <= 1'b0;
         end else begin
            rsp_bin_index      <= 10'(addr_ff);
            rsp_bin_total      <= 32'(newc);
            rsp_sample_counted <= 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/uniform_bin_histogram_core.sv
`default_nettype none
// Fixed-width bin histogram over signed Q16.16 samples.
// Request channel: drive req_* and raise start while busy is low; the
// request is taken at that edge. operation 0 adds a sample (skipped when
// req_sample_invalid), operation 1 reads bin req_bin_select and optionally
// clears it.
// Response: rsp_strobe is high for one cycle with bin index, bin total and
// the counted flag; the receiver cannot stall and must take it then.
// Steps: an add of a sample at or above range_minimum runs a restoring
// divider one quotient bit per cycle (33 steps); reads, skipped and
// below-range samples skip it. The store read, wait and write states
// follow; rsp_strobe is registered from the write state. One request at
// a time: the next is taken once busy falls, in the strobe cycle.
// Configuration: csr_valid/csr_ready with csr_index and csr_data; write
// only while busy is low and no response pending.
// Reset (synchronous, active high) sets registers to their defaults and
// sweeps the count store to zero, one entry a cycle, with busy high.
module uniform_bin_histogram_core #(
   parameter int MAX_BINS    = 1024,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_operation,
   input  wire logic signed [31:0] req_sample_value,
   input  wire logic               req_sample_invalid,
   input  wire logic [9:0]         req_bin_select,
   input  wire logic               req_clear_after_read,
   output logic                    rsp_strobe,
   output logic [9:0]              rsp_bin_index,
   output logic [31:0]             rsp_bin_total,
   output logic                    rsp_sample_counted,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

   ubh_pkg::ubh_cmd_type  cmd;
   ubh_pkg::ubh_stat_type stat;

   assign csr_ready = 1'b1;

   ubh_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   ubh_datapath #(
      .MAX_BINS    (MAX_BINS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .csr_valid            (csr_valid),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_operation        (req_operation),
      .req_sample_value     (req_sample_value),
      .req_sample_invalid   (req_sample_invalid),
      .req_bin_select       (req_bin_select),
      .req_clear_after_read (req_clear_after_read),
      .rsp_strobe           (rsp_strobe),
      .rsp_bin_index        (rsp_bin_index),
      .rsp_bin_total        (rsp_bin_total),
      .rsp_sample_counted   (rsp_sample_counted)
   );

endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps

// Tracks histogram bin counts and checks each response against them.
class histogram_scoreboard;
   bit [31:0]   counts [1024];
   bit [10:0]   bins_in_use;
   bit [31:0]   range_min;
   bit [30:0]   width;
   bit [9:0]    exp_index [$];
   bit [31:0]   exp_total [$];
   bit          exp_counted [$];
   int          mismatches;
   int          checked;

   function new();
      foreach (counts[i]) counts[i] = 0;
      bins_in_use = 11'd1024;
      range_min   = 0;
      width       = 31'd65536;
      mismatches  = 0;
      checked     = 0;
   endfunction

   function void write_reg(bit [1:0] idx, bit [31:0] data);
      case (idx)
         ubh_pkg::CSR_BIN_COUNT: bins_in_use = data[10:0];
         ubh_pkg::CSR_RANGE_MIN: range_min   = data;
         ubh_pkg::CSR_BIN_WIDTH: width       = data[30:0];
         default: ;
      endcase
   endfunction

   // bin that a sample falls into, clamped to the bins in use
   function bit [9:0] locate(bit [31:0] sample);
      longint diff;
      longint w;
      longint last;
      longint q;
      diff = longint'($signed(sample)) - longint'($signed(range_min));
      w    = (width == 0) ? 1 : longint'(width);
      last = (bins_in_use == 0) ? 0 :
             (bins_in_use > 1024) ? 1023 : longint'(bins_in_use) - 1;
      if (diff < 0) return 10'd0;
      q = diff / w;
      return (q > last) ? last[9:0] : q[9:0];
   endfunction

   // note an accepted request and queue its expected response
   function void note_request(bit op, bit [31:0] sample, bit invalid,
                              bit [9:0] sel, bit clr);
      bit [9:0]  idx;
      bit [31:0] total;
      bit        counted;
      idx = 0;
      total = 0;
      counted = 0;
      if (op == ubh_pkg::OP_ADD) begin
         if (!invalid) begin
            idx = locate(sample);
            if (counts[idx] != 32'hFFFF_FFFF) counts[idx]++;
            total = counts[idx];
            counted = 1;
         end
      end else begin
         idx = sel;
         total = counts[idx];
         if (clr) counts[idx] = 0;
      end
      exp_index.push_back(idx);
      exp_total.push_back(total);
      exp_counted.push_back(counted);
   endfunction

   function void check_response(bit [9:0] idx, bit [31:0] total, bit counted);
      bit [9:0]  e_idx;
      bit [31:0] e_total;
      bit        e_cnt;
      if (exp_index.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: unexpected response idx=%0d total=%0d counted=%0b",
                     idx, total, counted);
         return;
      end
      e_idx = exp_index.pop_front();
      e_total = exp_total.pop_front();
      e_cnt = exp_counted.pop_front();
      checked++;
      if (idx !== e_idx || total !== e_total || counted !== e_cnt) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: exp idx=%0d total=%0d counted=%0b, %s%0d %s%0d %s%0b",
                     e_idx, e_total, e_cnt, "got idx=", idx, "total=", total,
                     "counted=", counted);
      end
   endfunction

   function int pending();
      return exp_index.size();
   endfunction
endclass

module testbench;
   localparam int STALL_LIMIT = 20000;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_operation;
   logic signed [31:0] req_sample_value;
   logic              req_sample_invalid;
   logic [9:0]        req_bin_select;
   logic              req_clear_after_read;
   logic              rsp_strobe;
   logic [9:0]        rsp_bin_index;
   logic [31:0]       rsp_bin_total;
   logic              rsp_sample_counted;
   logic              csr_valid;
   logic              csr_ready;
   logic [1:0]        csr_index;
   logic [31:0]       csr_data;

   histogram_scoreboard hist;
   int idle_pct;
   int quiet_cycles = 0;
   int requests_sent;
   int adds_sent;
   int reads_sent;
   int csr_writes;

   uniform_bin_histogram_core dut (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // response checking and watchdog, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            hist.check_response(rsp_bin_index, rsp_bin_total, rsp_sample_counted);
         if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic write_csr(bit [1:0] idx, bit [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      hist.write_reg(idx, data);
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_request(bit op, bit [31:0] sample, bit invalid,
                               bit [9:0] sel, bit clr);
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      @(negedge clock);
      start                <= 1'b1;
      req_operation        <= op;
      req_sample_value     <= sample;
      req_sample_invalid   <= invalid;
      req_bin_select       <= sel;
      req_clear_after_read <= clr;
      do @(posedge clock); while (busy);
      hist.note_request(op, sample, invalid, sel, clr);
      requests_sent++;
      if (op == ubh_pkg::OP_ADD) adds_sent++; else reads_sent++;
      @(negedge clock);
      start <= 1'b0;
   endtask

   // wait until all responses are back, then let the pipeline settle
   task automatic drain();
      while (hist.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic random_add();
      bit [31:0] v;
      case ($urandom_range(3))
         0: v = $urandom;
         1: v = hist.range_min + $urandom_range(hist.width * 8 + 1);
         default: v = hist.range_min + ($urandom_range(40) - 4) * hist.width
                      + $urandom_range(3);
      endcase
      send_request(ubh_pkg::OP_ADD, v, $urandom_range(9) == 0, 10'($urandom),
                   1'($urandom));
   endtask

   task automatic random_read();
      bit [9:0] sel;
      sel = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(40));
      send_request(ubh_pkg::OP_READ, $urandom, 1'($urandom), sel,
                   1'($urandom_range(1)));
   endtask

   task automatic random_phase(int n, int pct);
      idle_pct = pct;
      repeat (n) begin
         if ($urandom_range(3) == 0) random_read();
         else random_add();
      end
      drain();
   endtask

   initial begin
      hist = new();
      reset = 1'b1;
      start = 1'b0;
      req_operation = ubh_pkg::OP_ADD;
      req_sample_value = '0;
      req_sample_invalid = 1'b0;
      req_bin_select = '0;
      req_clear_after_read = 1'b0;
      csr_valid = 1'b0;
      csr_index = ubh_pkg::CSR_BIN_COUNT;
      csr_data = '0;
      idle_pct = 0;
      requests_sent = 0;
      adds_sent = 0;
      reads_sent = 0;
      csr_writes = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: default settings, field extremes, special cases
      send_request(ubh_pkg::OP_ADD, 32'h7FFF_FFFF, 1'b0, 10'h3FF, 1'b1);
      send_request(ubh_pkg::OP_ADD, 32'h8000_0000, 1'b0, 10'h000, 1'b0);
      send_request(ubh_pkg::OP_ADD, 32'h0000_0000, 1'b0, 10'h155, 1'b0);
      send_request(ubh_pkg::OP_ADD, 32'h0001_FFFF, 1'b0, 10'h2AA, 1'b1);
      send_request(ubh_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b1, 10'h3FF, 1'b1);
      send_request(ubh_pkg::OP_ADD, 32'h5555_5555, 1'b1, 10'h000, 1'b0);
      send_request(ubh_pkg::OP_READ, 32'hAAAA_AAAA, 1'b0, 10'd1023, 1'b0);
      send_request(ubh_pkg::OP_READ, 32'h5555_5555, 1'b1, 10'd1023, 1'b1);
      send_request(ubh_pkg::OP_READ, 32'h0, 1'b0, 10'd1023, 1'b0);
      send_request(ubh_pkg::OP_READ, 32'h0, 1'b0, 10'd0, 1'b1);
      send_request(ubh_pkg::OP_READ, 32'h0, 1'b0, 10'd1, 1'b0);
      drain();

      // bin count zero and over-size, width zero and maximum
      write_csr(ubh_pkg::CSR_BIN_COUNT, 32'd0);
      write_csr(ubh_pkg::CSR_BIN_WIDTH, 32'd0);
      write_csr(ubh_pkg::CSR_RANGE_MIN, 32'h8000_0000);
      send_request(ubh_pkg::OP_ADD, 32'h7FFF_FFFF, 1'b0, 10'd0, 1'b0);
      send_request(ubh_pkg::OP_READ, 32'h0, 1'b0, 10'd0, 1'b0);
      drain();
      write_csr(ubh_pkg::CSR_BIN_COUNT, 32'h7FF);
      write_csr(ubh_pkg::CSR_BIN_WIDTH, 32'h7FFF_FFFF);
      send_request(ubh_pkg::OP_ADD, 32'h7FFF_FFFF, 1'b0, 10'd0, 1'b0);
      send_request(ubh_pkg::OP_ADD, 32'h8000_0000, 1'b0, 10'd0, 1'b0);
      send_request(ubh_pkg::OP_READ, 32'h0, 1'b0, 10'd1, 1'b1);
      drain();
      write_csr(ubh_pkg::CSR_RANGE_MIN, 32'h7FFF_FFFF);
      write_csr(ubh_pkg::CSR_BIN_WIDTH, 32'd1);
      write_csr(ubh_pkg::CSR_BIN_COUNT, 32'd1024);
      send_request(ubh_pkg::OP_ADD, 32'h8000_0000, 1'b0, 10'd0, 1'b0);
      send_request(ubh_pkg::OP_ADD, 32'h7FFF_FFFF, 1'b0, 10'd0, 1'b0);
      drain();

      // random phases over several settings
      write_csr(ubh_pkg::CSR_RANGE_MIN, 32'hFFF6_0000);
      write_csr(ubh_pkg::CSR_BIN_WIDTH, 32'h0001_0000);
      write_csr(ubh_pkg::CSR_BIN_COUNT, 32'd20);
      random_phase(130, 0);
      write_csr(ubh_pkg::CSR_BIN_COUNT, 32'd1);
      write_csr(ubh_pkg::CSR_BIN_WIDTH, 32'd3);
      random_phase(60, 57);
      write_csr(ubh_pkg::CSR_BIN_COUNT, 32'd1024);
      write_csr(ubh_pkg::CSR_RANGE_MIN, 32'h0);
      write_csr(ubh_pkg::CSR_BIN_WIDTH, 32'd7);
      random_phase(130, 57);
      // sender holds off until every response is back, then resumes
      write_csr(ubh_pkg::CSR_BIN_COUNT, 32'd33);
      write_csr(ubh_pkg::CSR_RANGE_MIN, $urandom);
      write_csr(ubh_pkg::CSR_BIN_WIDTH, 32'h0000_8000);
      random_phase(130, 13);
      write_csr(ubh_pkg::CSR_BIN_COUNT, 32'd2);
      write_csr(ubh_pkg::CSR_BIN_WIDTH, 32'h4000_0000);
      write_csr(ubh_pkg::CSR_RANGE_MIN, 32'hC000_0000);
      random_phase(100, 0);
      write_csr(ubh_pkg::CSR_BIN_COUNT, 32'd1500);
      write_csr(ubh_pkg::CSR_BIN_WIDTH, 32'h0010_0000);
      write_csr(ubh_pkg::CSR_RANGE_MIN, 32'h8000_0000);
      random_phase(100, 30);

      $display("Sent %0d requests (%0d adds, %0d reads), %0d register writes;",
               requests_sent, adds_sent, reads_sent, csr_writes);
      $display("checked %0d responses, %0d mismatches.", hist.checked, hist.mismatches);
      if (hist.mismatches == 0 && hist.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
